// ===== rtl/wsr_pkg.sv =====
package wsr_pkg;

  // Field and state widths
  localparam int SMP_W    = 16;
  localparam int CNT_W    = 24;
  localparam int POS_W    = 40;
  localparam int STRIDE_W = 17;
  localparam int CUT_W    = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Register reset values and limits
  localparam logic [STRIDE_W-1:0] STRIDE_ONE = 17'h10000;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 17'h10000;
  localparam logic [CUT_W-1:0]    CUTOFF_RST = 16'd65529;

  // Register indexes, taken from paddr[2]
  localparam logic REG_STRIDE = 1'b0;
  localparam logic REG_CUTOFF = 1'b1;

  // Weight datapath widths
  localparam int ROM_W = 32;
  localparam int SIN_W = 33;
  localparam int SC_W  = 33;
  localparam int W_W   = 34;
  localparam int WGT_W = 34;

  // Fixed-point constants
  localparam longint PI_Q29  = 64'sd1686629713;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PC1     = 64'sd1686629713;
  localparam longint PC3     = -64'sd693598668;
  localparam longint PC5     = 64'sd85569306;
  localparam longint PC7     = -64'sd5026994;
  localparam longint PC9     = 64'sd172272;

endpackage

// ===== rtl/wsr_div.sv =====
module wsr_div
  import wsr_pkg::*;
#(
  parameter int DVD_W = 63,
  parameter int DVS_W = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   rem_sh, rem_sub;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/wsr_weight.sv =====
module wsr_weight
  import wsr_pkg::*;
#(
  parameter int HALF         = 128,
  parameter int SINE_ENTRIES = 1024,
  parameter int XW           = $clog2(HALF) + 18
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [XW-1:0]    xq_i,
  input  logic        [CUT_W-1:0] cutoff_i,
  output logic                    done_o,
  output logic signed [WGT_W-1:0] weight_o
);

  localparam int AW    = $clog2(SINE_ENTRIES);
  localparam int IQ_W  = 33 + AW;
  localparam int DEN_W = 16 + XW;
  localparam int DVD_W = SIN_W + 30;
  localparam int PR_W  = ROM_W + 35;
  localparam int SPAN  = 2 * HALF * 65536;
  localparam int MID   = HALF * 65536;
  localparam int WSH   = $clog2(2 * HALF);

  localparam logic [3:0] W_IDLE  = 4'd0;
  localparam logic [3:0] W_PREP  = 4'd1;
  localparam logic [3:0] W_IQ    = 4'd2;
  localparam logic [3:0] W_RD    = 4'd3;
  localparam logic [3:0] W_DIFF  = 4'd4;
  localparam logic [3:0] W_MUL   = 4'd5;
  localparam logic [3:0] W_SIN   = 4'd6;
  localparam logic [3:0] W_DIVS  = 4'd7;
  localparam logic [3:0] W_WAITS = 4'd8;
  localparam logic [3:0] W_WIN   = 4'd9;
  localparam logic [3:0] W_SQ    = 4'd11;
  localparam logic [3:0] W_OUT   = 4'd12;

  typedef logic signed [ROM_W-1:0] rom_t [SINE_ENTRIES];

  // Full-wave sine table in Q2.30 from an odd polynomial over the quarter wave
  function automatic rom_t build_rom();
    rom_t   t;
    longint q4;
    longint quad;
    longint r;
    longint z2;
    longint p;
    for (int n = 0; n < SINE_ENTRIES; n++) begin
      q4   = 4 * n;
      quad = q4 / SINE_ENTRIES;
      r    = ((q4 % SINE_ENTRIES) <<< 30) / SINE_ENTRIES;
      if (quad[0]) r = ONE_Q30 - r;
      z2 = (r * r) >>> 30;
      p  = PC9;
      p  = PC7 + ((p * z2) >>> 30);
      p  = PC5 + ((p * z2) >>> 30);
      p  = PC3 + ((p * z2) >>> 30);
      p  = PC1 + ((p * z2) >>> 30);
      p  = (p * r) >>> 30;
      if (p > ONE_Q30) p = ONE_Q30;
      if (p < 0) p = 0;
      t[n] = ROM_W'((quad >= 2) ? -p : p);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [3:0]              st_q, st_d;
  logic                    pass_q;
  logic                    done_q;
  logic signed [XW-1:0]    xq_q;
  logic [32:0]             phase_q;
  logic [DEN_W-1:0]        den_q;
  logic [IQ_W-1:0]         iq_q;
  logic [32:0]             frac_q;
  logic signed [ROM_W-1:0] rom_a_q, rom_b_q, base_q;
  logic signed [ROM_W:0]   diff_q;
  logic signed [PR_W-1:0]  prod_q;
  logic signed [SIN_W-1:0] sin_q;
  logic signed [SC_W-1:0]  sc_q;
  logic signed [W_W-1:0]   w_q;
  logic signed [WGT_W-1:0] weight_q;

  logic [AW-1:0]             idx, nxt;
  logic signed [XW+CUT_W:0]  ph_full;
  logic [XW-1:0]             xm;
  logic [30+XW:0]            den_full;
  logic [SIN_W-1:0]          sin_abs;
  logic signed [XW:0]        nn;
  logic [XW-1:0]             n_cl;
  logic                      div_start, div_done;
  logic [DVD_W-1:0]          dvd, quot;
  logic [DEN_W-1:0]          dvs;
  logic signed [2*SIN_W-1:0] sq;
  logic signed [SC_W+W_W-1:0] scw;
  logic                      q_neg;
  logic signed [SC_W-1:0]    q_mag;

  // Datapath helpers
  always_comb begin
    idx      = iq_q[IQ_W-1:33];
    nxt      = (idx == AW'(SINE_ENTRIES - 1)) ? '0 : idx + 1'b1;
    ph_full  = xq_q * $signed({1'b0, cutoff_i});
    xm       = xq_q[XW-1] ? XW'(-xq_q) : XW'(xq_q);
    den_full = (31 + XW)'(PI_Q29) * (31 + XW)'(xm);
    sin_abs  = sin_q[SIN_W-1] ? SIN_W'(-sin_q) : SIN_W'(sin_q);
    nn       = (XW + 1)'(xq_q) + (XW + 1)'(MID);
    if (nn < 0) begin
      n_cl = '0;
    end else if (nn > (XW + 1)'(SPAN)) begin
      n_cl = XW'(SPAN);
    end else begin
      n_cl = nn[XW-1:0];
    end
    sq    = sin_q * sin_q;
    scw   = sc_q * w_q;
    q_neg = sin_q[SIN_W-1] != xq_q[XW-1];
    q_mag = $signed({1'b0, quot[31:0]});
  end

  // Feed the divider with the sinc quotient
  always_comb begin
    div_start = (st_q == W_DIVS);
    dvd       = DVD_W'({sin_abs, 30'b0});
    dvs       = den_q;
  end

  wsr_div #(
    .DVD_W(DVD_W),
    .DVS_W(DEN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dvd),
    .divisor_i (dvs),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Sequence one tap weight
  always_comb begin
    st_d = st_q;
    case (st_q)
      W_IDLE:  if (start_i) st_d = W_PREP;
      W_PREP:  st_d = (xq_q == '0) ? W_WIN : W_IQ;
      W_IQ:    st_d = W_RD;
      W_RD:    st_d = W_DIFF;
      W_DIFF:  st_d = W_MUL;
      W_MUL:   st_d = W_SIN;
      W_SIN:   st_d = pass_q ? W_SQ : W_DIVS;
      W_DIVS:  st_d = W_WAITS;
      W_WAITS: if (div_done) st_d = W_WIN;
      W_WIN:   st_d = W_IQ;
      W_SQ:    st_d = W_OUT;
      W_OUT:   st_d = W_IDLE;
      default: st_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= W_IDLE;
      pass_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == W_OUT);
      if (st_q == W_PREP) pass_q <= 1'b0;
      else if (st_q == W_WIN) pass_q <= 1'b1;
    end
  end

  // Sine table read, registered
  always_ff @(posedge clk_i) begin
    rom_a_q <= SINE_ROM[idx];
    rom_b_q <= SINE_ROM[nxt];
  end

  // Hold intermediate products
  always_ff @(posedge clk_i) begin
    if (st_q == W_IDLE && start_i) xq_q <= xq_i;
    if (st_q == W_PREP) begin
      phase_q <= ph_full[32:0];
      den_q   <= DEN_W'(den_full >> 15);
      sc_q    <= SC_W'({cutoff_i, 14'b0});
    end
    if (st_q == W_IQ) iq_q <= IQ_W'(phase_q) * IQ_W'(SINE_ENTRIES);
    if (st_q == W_RD) frac_q <= iq_q[32:0];
    if (st_q == W_DIFF) begin
      diff_q <= {rom_b_q[ROM_W-1], rom_b_q} - {rom_a_q[ROM_W-1], rom_a_q};
      base_q <= rom_a_q;
    end
    if (st_q == W_MUL) prod_q <= diff_q * $signed({1'b0, frac_q});
    if (st_q == W_SIN) sin_q <= SIN_W'($signed({base_q[ROM_W-1], base_q}) + (prod_q >>> 33));
    if (st_q == W_WAITS && div_done) sc_q <= q_neg ? -q_mag : q_mag;
    // Window phase: scale the clamped offset by the window span, a power of two
    if (st_q == W_WIN) phase_q <= 33'({n_cl, 16'b0} >> WSH);
    if (st_q == W_SQ) w_q <= W_W'(sq >>> 30);
    if (st_q == W_OUT) weight_q <= WGT_W'(scw >>> 30);
  end

  assign done_o   = done_q;
  assign weight_o = weight_q;

endmodule

// ===== rtl/windowed_sinc_resampler.sv =====
// Windowed-sinc resampler with a Hann window over TAPS history samples. Each
// item is a source sample or a padding tick and is written to a 256-entry
// history RAM; an item that yields no result goes back to idle after its
// evaluation. An item that yields a result walks every tap in turn: a tap whose
// history word is zero or out of range skips the weight unit, and a live tap
// waits for the weight unit (one table interpolation at zero offset, otherwise
// two table interpolations and one 63-step division in a radix-2 divider). A
// result may wait for a free output register, and the block takes no new item
// until that result is loaded into the output register.
// stride and cutoff sit at byte addresses 0 and 4.
module windowed_sinc_resampler
  import wsr_pkg::*;
#(
  parameter int TAPS         = 256,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic signed [SMP_W-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SMP_W-1:0] out_sample_o,
  output logic [CNT_W-1:0]        out_index_o
);

  localparam int HALF  = TAPS / 2;
  localparam int AW    = $clog2(TAPS);
  localparam int DW    = $clog2(TAPS + 1);
  localparam int JW    = $clog2(TAPS) + 1;
  localparam int XW    = $clog2(HALF) + 18;
  localparam int XQF_W = JW + 18;
  localparam int C_W   = POS_W - 15;
  localparam int K_W   = C_W + 2;
  localparam int ACC_W = SMP_W + WGT_W + $clog2(TAPS) + 1;
  localparam int MAG_W = 46;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EVAL  = 4'd1;
  localparam logic [3:0] ST_ADDR  = 4'd2;
  localparam logic [3:0] ST_DATA  = 4'd3;
  localparam logic [3:0] ST_WAIT  = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_NEXT  = 4'd6;
  localparam logic [3:0] ST_CLAMP = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [STRIDE_W-1:0] stride_q;
  logic [CUT_W-1:0]    cutoff_q;
  logic [AW-1:0]       wp_q;
  logic [CNT_W-1:0]    sp_q, scount_q, oc_q;
  logic [POS_W-1:0]    pos_q;
  logic [C_W-1:0]      c_q;
  logic signed [17:0]  off_q;
  logic signed [JW-1:0] j_q;
  logic                tap_ok_q;
  logic signed [SMP_W-1:0] hist_rd_q, h_q;
  logic signed [SMP_W+WGT_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                neg_q;
  logic [MAG_W-1:0]    mag_q;
  logic [MAG_W+14:0]   scale_q;
  logic                out_valid_q;
  logic signed [SMP_W-1:0] out_sample_q;
  logic [CNT_W-1:0]    out_index_q;

  logic signed [SMP_W-1:0] hist_mem [TAPS];

  logic                in_acc, cfg_wr, out_load;
  logic [STRIDE_W-1:0] st_eff;
  logic [POS_W:0]      pos_r, pos_plus, limit;
  logic [C_W-1:0]      c_new;
  logic [POS_W+1:0]    off_full;
  logic [K_W-1:0]      need;
  logic                go;
  logic signed [K_W-1:0] k, d;
  logic [AW:0]         addr_s;
  logic [AW-1:0]       rd_addr;
  logic                tap_ok;
  logic signed [XQF_W-1:0] xq_full;
  logic signed [XW-1:0] xq;
  logic                wt_start, wt_done;
  logic signed [WGT_W-1:0] weight;
  logic [ACC_W-1:0]    acc_abs;
  logic [SMP_W-1:0]    res_mag;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_CUTOFF) ? APB_DW'(cutoff_q) : APB_DW'(stride_q);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Decide whether this item yields an output
  always_comb begin
    st_eff   = (stride_q < STRIDE_ONE) ? STRIDE_ONE : stride_q;
    pos_r    = {1'b0, pos_q} + (POS_W + 1)'(32768);
    c_new    = pos_r[POS_W:16];
    off_full = {1'b0, c_new, 16'b0} - {2'b0, pos_q};
    need     = K_W'(c_new) + K_W'(TAPS - HALF);
    pos_plus = {1'b0, pos_q} + (POS_W + 1)'(st_eff);
    limit    = {1'b0, scount_q, 16'b0};
    go       = (K_W'(sp_q) >= need) && (pos_plus <= limit);
  end

  // Locate the current tap in the history
  always_comb begin
    k       = $signed(K_W'(c_q)) + K_W'(j_q);
    d       = $signed(K_W'(sp_q)) - k;
    tap_ok  = (k >= 0) && (d >= 1) && (d <= $signed(K_W'(TAPS)));
    addr_s  = (AW + 1)'(wp_q) + (AW + 1)'(TAPS) - (AW + 1)'(d[DW-1:0]);
    if (addr_s >= (AW + 1)'(TAPS)) addr_s = addr_s - (AW + 1)'(TAPS);
    rd_addr = addr_s[AW-1:0];
    xq_full = (XQF_W'(j_q) <<< 16) + XQF_W'(off_q);
    xq      = XW'(xq_full);
  end

  assign wt_start = (state_q == ST_DATA) && tap_ok_q && (hist_rd_q != '0);

  wsr_weight #(
    .HALF        (HALF),
    .SINE_ENTRIES(SINE_ENTRIES),
    .XW          (XW)
  ) u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wt_start),
    .xq_i    (xq),
    .cutoff_i(cutoff_q),
    .done_o  (wt_done),
    .weight_o(weight)
  );

  // Clamp and scale helpers
  always_comb begin
    acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    res_mag = {1'b0, scale_q[MAG_W+13:MAG_W-1]};
  end

  // Sequence the tap walk
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_EVAL;
      ST_EVAL:  state_d = go ? ST_ADDR : ST_IDLE;
      ST_ADDR:  state_d = ST_DATA;
      ST_DATA:  state_d = wt_start ? ST_WAIT : ST_NEXT;
      ST_WAIT:  if (wt_done) state_d = ST_ACC;
      ST_ACC:   state_d = ST_NEXT;
      ST_NEXT:  state_d = (j_q == JW'(TAPS - HALF - 1)) ? ST_CLAMP : ST_ADDR;
      ST_CLAMP: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stride_q    <= STRIDE_RST;
      cutoff_q    <= CUTOFF_RST;
      wp_q        <= '0;
      sp_q        <= '0;
      scount_q    <= '0;
      pos_q       <= '0;
      oc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_STRIDE) stride_q <= pwdata[STRIDE_W-1:0];
        else cutoff_q <= pwdata[CUT_W-1:0];
      end
      if (in_acc) begin
        wp_q <= (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
        if (sp_q != '1) sp_q <= sp_q + 1'b1;
        if (!mode_i && scount_q != '1) scount_q <= scount_q + 1'b1;
      end
      if (state_q == ST_EVAL && go) pos_q <= pos_plus[POS_W-1:0];
      if (out_load) begin
        out_valid_q <= 1'b1;
        oc_q        <= oc_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // History RAM: write on accept, registered read
  always_ff @(posedge clk_i) begin
    if (in_acc) hist_mem[wp_q] <= mode_i ? '0 : sample_i;
    hist_rd_q <= hist_mem[rd_addr];
  end

  // Tap walk datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      c_q   <= c_new;
      off_q <= off_full[17:0];
      j_q   <= -JW'(HALF);
      acc_q <= '0;
    end
    if (state_q == ST_ADDR) tap_ok_q <= tap_ok;
    if (wt_start) h_q <= hist_rd_q;
    if (state_q == ST_WAIT && wt_done) prod_q <= h_q * weight;
    if (state_q == ST_ACC) acc_q <= acc_q + ACC_W'(prod_q);
    if (state_q == ST_NEXT) j_q <= j_q + 1'b1;
    if (state_q == ST_CLAMP) begin
      neg_q <= acc_q[ACC_W-1];
      mag_q <= (acc_abs > ACC_W'(64'd1 << 45)) ? MAG_W'(64'd1 << 45) : acc_abs[MAG_W-1:0];
    end
    if (state_q == ST_SCALE) scale_q <= (MAG_W + 15)'(mag_q) * (MAG_W + 15)'(32767);
    if (out_load) begin
      out_sample_q <= neg_q ? -$signed(res_mag) : $signed(res_mag);
      out_index_q  <= oc_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_index_o  = out_index_q;

  // A weight result only arrives while the walk waits for it
  a_wt_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wt_done |-> state_q == ST_WAIT)
    else $error("weight result outside tap wait");

  // An accepted item is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EVAL)
    else $error("accepted item not evaluated");

  // Source count never passes the stream position
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q >= scount_q)
    else $error("source count above stream position");

  // Output sequence number moves only when a result is loaded
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oc_q != $past(oc_q)) |-> ($past(state_q) == ST_OUT))
    else $error("output count moved outside output load");

endmodule
